// File: rtl/core/rsl_pkg.sv
package rsl_pkg;

	// store geometry
	localparam int MAX_PARTICLES = 1024;
	localparam int IDX_W         = $clog2(MAX_PARTICLES);
	localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);

	// shared datapath
	localparam int DW     = 48;
	localparam int MA_W   = 25;
	localparam int MB_W   = 22;
	localparam int PROD_W = MA_W + MB_W;

	localparam logic signed [DW-1:0] S32_MAX = DW'(64'sd2147483647);
	localparam logic signed [DW-1:0] S32_MIN = ~S32_MAX;
	localparam logic signed [DW-1:0] ONE_Q20 = DW'(64'sd1048576);

	// stream and configuration port widths
	localparam int S_TDATA_W  = 96;
	localparam int S_TUSER_W  = 2;
	localparam int M_TDATA_W  = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration reset values
	localparam logic [CNT_W-1:0] COUNT_RST = CNT_W'(2);
	localparam logic [31:0]      BOX_RST   = 32'd1048576;
	localparam logic [23:0]      STIFF_RST = 24'd65536;
	localparam logic [23:0]      TSTEP_RST = 24'd16777;
	localparam logic [23:0]      NAMP_RST  = 24'd0;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_FORCES  = 2'd1,
		OP_ADVANCE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COUNT = 3'd0,
		REG_BOX   = 3'd1,
		REG_STIFF = 3'd2,
		REG_TSTEP = 3'd3,
		REG_NAMP  = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ALU_ADD   = 3'd0,
		ALU_SUB   = 3'd1,
		ALU_MUL   = 3'd2,
		ALU_ASR8  = 3'd3,
		ALU_ASR16 = 3'd4,
		ALU_WRAP  = 3'd5,
		ALU_SAT   = 3'd6
	} alu_op_t;

endpackage

// File: rtl/core/ring_soft_repulsion_langevin_step_unit.sv
// compute forces walks the n particles in use
// (n = particle_count capped at 1024)
// one word in flight; the next word can be taken in the cycle after the result is queued
// the forces walk runs on the single shared alu/multiplier
// async active-low reset; afterwards a pass zeroes the force store,
// input not ready meanwhile; config writes are taken at any time
module ring_soft_repulsion_langevin_step_unit import rsl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// particle_index[9:0], position_in[41:10], noise_sample[57:42],
	// apply_external[58], external_force[90:59], zero pad[95:91]
	input  logic [S_TDATA_W-1:0]  s_tdata,
	// operation[1:0]
	input  logic [S_TUSER_W-1:0]  s_tuser,
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// position_out[31:0], force_out[63:32]
	output logic [M_TDATA_W-1:0]  m_tdata
);

	// one-hot sequencer
	typedef enum logic [18:0] {
		ST_CLEAR     = 19'h00001,
		ST_IDLE      = 19'h00002,
		ST_LOAD      = 19'h00004,
		ST_READ      = 19'h00008,
		ST_READ2     = 19'h00010,
		ST_ADV_FETCH = 19'h00020,
		ST_ADV_EXEC  = 19'h00040,
		ST_ADV_WRITE = 19'h00080,
		ST_FRC_START = 19'h00100,
		ST_FRC_PREV  = 19'h00200,
		ST_FRC_DIFF  = 19'h00400,
		ST_FRC_WRAP  = 19'h00800,
		ST_FRC_SPAN  = 19'h01000,
		ST_FRC_MUL   = 19'h02000,
		ST_FRC_SHIFT = 19'h04000,
		ST_FRC_EMIT  = 19'h08000,
		ST_FRC_LAST  = 19'h10000,
		ST_FRD       = 19'h20000,
		ST_FIN       = 19'h40000
	} state_t;

	// micro steps of the advance
	typedef enum logic [3:0] {
		AS_DRIVE     = 4'd0,
		AS_MUL_LO    = 4'd1,
		AS_MUL_HI    = 4'd2,
		AS_SHR_LO    = 4'd3,
		AS_SUM_HI    = 4'd4,
		AS_SHR_DRIFT = 4'd5,
		AS_MUL_NOISE = 4'd6,
		AS_SHR_NOISE = 4'd7,
		AS_ADD_NOISE = 4'd8,
		AS_ADD_POS   = 4'd9,
		AS_WRAP      = 4'd10,
		AS_SAT       = 4'd11
	} adv_step_t;

	function automatic logic signed [DW-1:0] sext32(input logic [31:0] x);
		return $signed({{(DW - 32){x[31]}}, x});
	endfunction

	function automatic logic signed [DW-1:0] sext16(input logic [15:0] x);
		return $signed({{(DW - 16){x[15]}}, x});
	endfunction

	function automatic logic signed [DW-1:0] zext24(input logic [23:0] x);
		return $signed({{(DW - 24){1'b0}}, x});
	endfunction

	state_t            state_q;
	adv_step_t         step_q;
	logic [CNT_W-1:0]  j_q;
	logic [IDX_W-1:0]  clr_q;

	// config registers
	logic [CNT_W-1:0]  count_q;
	logic [31:0]       box_q;
	logic [23:0]       stiff_q;
	logic [23:0]       tstep_q;
	logic [23:0]       namp_q;

	// latched word
	logic [IDX_W-1:0]  idx_q;
	logic [31:0]       pos_in_q;
	logic [15:0]       noise_q;
	logic [31:0]       ext_q;

	// working registers
	logic signed [DW-1:0] r0_q;
	logic signed [DW-1:0] r1_q;
	logic signed [DW-1:0] fprev_q;
	logic signed [DW-1:0] f0_q;
	logic [31:0]          prev_q;
	logic                 in_rng_q;
	logic [31:0]          pos_res_q;

	// output register
	logic                 m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	// memories
	logic [31:0] pos_mem [MAX_PARTICLES];
	logic [31:0] frc_mem [MAX_PARTICLES];
	logic [31:0] pos_rd_q;
	logic [31:0] frc_rd_q;

	logic             pos_we, pos_re, frc_we, frc_re;
	logic [IDX_W-1:0] pos_wa, pos_ra, frc_wa, frc_ra;
	logic [31:0]      pos_wd, frc_wd;

	// shared alu
	alu_op_t              alu_op;
	logic signed [DW-1:0] alu_a, alu_b, alu_y;
	logic                 r0_we, r1_we;

	logic [CNT_W-1:0]     n_eff;
	logic [IDX_W-1:0]     last_idx;
	logic [CNT_W-1:0]     j_next;
	logic signed [DW-1:0] f_cur;
	logic                 slot_free;
	logic                 queue_word;

	assign n_eff    = (count_q > CNT_W'(MAX_PARTICLES)) ? CNT_W'(MAX_PARTICLES) : count_q;
	assign last_idx = IDX_W'(n_eff - CNT_W'(1));
	assign j_next   = j_q + CNT_W'(1);
	// pair force is zero outside the contact window
	assign f_cur    = in_rng_q ? r1_q : '0;
	assign slot_free = !m_tvalid_q || m_tready;
	// result word moves into the output register
	assign queue_word = (state_q == ST_FIN) && slot_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	rsl_alu u_alu (
		.op         (alu_op),
		.a          (alu_a),
		.b          (alu_b),
		.box_length (box_q),
		.y          (alu_y)
	);

	// datapath control and memory ports
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = r0_q;
		alu_b  = r1_q;
		r0_we  = 1'b0;
		r1_we  = 1'b0;
		pos_we = 1'b0;
		pos_wa = idx_q;
		pos_wd = pos_in_q;
		pos_re = 1'b0;
		pos_ra = idx_q;
		frc_we = 1'b0;
		frc_wa = clr_q;
		frc_wd = '0;
		frc_re = 1'b0;
		frc_ra = idx_q;
		case (state_q)
			ST_CLEAR:     frc_we = 1'b1;
			ST_LOAD:      pos_we = 1'b1;
			ST_READ:      pos_re = 1'b1;
			ST_ADV_FETCH: begin
				pos_re = 1'b1;
				frc_re = 1'b1;
			end
			ST_ADV_EXEC: begin
				case (step_q)
					AS_DRIVE: begin
						// stored force plus optional tracer force
						alu_a = sext32(frc_rd_q);
						alu_b = sext32(ext_q);
						r0_we = 1'b1;
					end
					AS_MUL_LO: begin
						alu_op = ALU_MUL;
						alu_a  = zext24(tstep_q);
						alu_b  = $signed({{(DW - 16){1'b0}}, r0_q[15:0]});
						r1_we  = 1'b1;
					end
					AS_MUL_HI: begin
						alu_op = ALU_MUL;
						alu_a  = zext24(tstep_q);
						alu_b  = $signed({{(DW - 17){r0_q[32]}}, r0_q[32:16]});
						r0_we  = 1'b1;
					end
					AS_SHR_LO: begin
						alu_op = ALU_ASR16;
						alu_a  = r1_q;
						r1_we  = 1'b1;
					end
					AS_SUM_HI:    r0_we = 1'b1;
					AS_SHR_DRIFT: begin
						alu_op = ALU_ASR8;
						r0_we  = 1'b1;
					end
					AS_MUL_NOISE: begin
						alu_op = ALU_MUL;
						alu_a  = zext24(namp_q);
						alu_b  = sext16(noise_q);
						r1_we  = 1'b1;
					end
					AS_SHR_NOISE: begin
						alu_op = ALU_ASR16;
						alu_a  = r1_q;
						r1_we  = 1'b1;
					end
					AS_ADD_NOISE: r0_we = 1'b1;
					AS_ADD_POS: begin
						alu_b = sext32(pos_rd_q);
						r0_we = 1'b1;
					end
					AS_WRAP: begin
						alu_op = ALU_WRAP;
						r0_we  = 1'b1;
					end
					AS_SAT: begin
						alu_op = ALU_SAT;
						r0_we  = 1'b1;
					end
					default: ;
				endcase
			end
			ST_ADV_WRITE: begin
				pos_we = 1'b1;
				pos_wd = r0_q[31:0];
			end
			ST_FRC_START: begin
				// predecessor of particle 0 is the last one in use
				pos_re = (n_eff != '0);
				pos_ra = last_idx;
			end
			ST_FRC_PREV: begin
				pos_re = 1'b1;
				pos_ra = j_q[IDX_W-1:0];
			end
			ST_FRC_DIFF: begin
				alu_op = ALU_SUB;
				alu_a  = sext32(pos_rd_q);
				alu_b  = sext32(prev_q);
				r0_we  = 1'b1;
			end
			ST_FRC_WRAP: begin
				alu_op = ALU_WRAP;
				r0_we  = 1'b1;
			end
			ST_FRC_SPAN: begin
				alu_op = ALU_SUB;
				alu_a  = ONE_Q20;
				alu_b  = r0_q;
				r1_we  = 1'b1;
			end
			ST_FRC_MUL: begin
				alu_op = ALU_MUL;
				alu_a  = zext24(stiff_q);
				alu_b  = r1_q;
				r1_we  = 1'b1;
			end
			ST_FRC_SHIFT: begin
				alu_op = ALU_ASR16;
				alu_a  = r1_q;
				r1_we  = 1'b1;
			end
			ST_FRC_EMIT: begin
				// previous particle's final force: its own pair minus the next pair
				alu_op = ALU_SUB;
				alu_a  = fprev_q;
				alu_b  = f_cur;
				frc_we = (j_q != '0);
				frc_wa = j_q[IDX_W-1:0] - IDX_W'(1);
				frc_wd = alu_y[31:0];
				pos_re = (j_next < n_eff);
				pos_ra = j_next[IDX_W-1:0];
			end
			ST_FRC_LAST: begin
				// last particle closes the ring against particle 0
				alu_op = ALU_SUB;
				alu_a  = fprev_q;
				alu_b  = f0_q;
				frc_we = 1'b1;
				frc_wa = last_idx;
				frc_wd = alu_y[31:0];
			end
			ST_FRD:       frc_re = 1'b1;
			default: ;
		endcase
	end

	// position store
	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[pos_wa] <= pos_wd;
		if (pos_re)
			pos_rd_q <= pos_mem[pos_ra];
	end

	// force store
	always_ff @(posedge clk) begin
		if (frc_we)
			frc_mem[frc_wa] <= frc_wd;
		if (frc_re)
			frc_rd_q <= frc_mem[frc_ra];
	end

	// sequencer, output valid and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			step_q     <= AS_DRIVE;
			j_q        <= '0;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			count_q    <= COUNT_RST;
			box_q      <= BOX_RST;
			stiff_q    <= STIFF_RST;
			tstep_q    <= TSTEP_RST;
			namp_q     <= NAMP_RST;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_COUNT: count_q <= cfg_data[CNT_W-1:0];
					REG_BOX:   box_q   <= cfg_data[31:0];
					REG_STIFF: stiff_q <= cfg_data[23:0];
					REG_TSTEP: tstep_q <= cfg_data[23:0];
					REG_NAMP:  namp_q  <= cfg_data[23:0];
					default: ;
				endcase
			end

			if (queue_word)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(MAX_PARTICLES - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						case (op_t'(s_tuser))
							OP_LOAD:    state_q <= ST_LOAD;
							OP_FORCES:  state_q <= ST_FRC_START;
							OP_ADVANCE: state_q <= ST_ADV_FETCH;
							OP_READ:    state_q <= ST_READ;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOAD:      state_q <= ST_FRD;
				ST_READ:      state_q <= ST_READ2;
				ST_READ2:     state_q <= ST_FRD;
				ST_ADV_FETCH: begin
					step_q  <= AS_DRIVE;
					state_q <= ST_ADV_EXEC;
				end
				ST_ADV_EXEC: begin
					step_q <= adv_step_t'(step_q + 4'd1);
					if (step_q == AS_SAT)
						state_q <= ST_ADV_WRITE;
				end
				ST_ADV_WRITE: state_q <= ST_FRD;
				ST_FRC_START: begin
					j_q <= '0;
					if (n_eff == '0)
						state_q <= ST_FRD;
					else
						state_q <= ST_FRC_PREV;
				end
				ST_FRC_PREV:  state_q <= ST_FRC_DIFF;
				ST_FRC_DIFF:  state_q <= ST_FRC_WRAP;
				ST_FRC_WRAP:  state_q <= ST_FRC_SPAN;
				ST_FRC_SPAN:  state_q <= ST_FRC_MUL;
				ST_FRC_MUL:   state_q <= ST_FRC_SHIFT;
				ST_FRC_SHIFT: state_q <= ST_FRC_EMIT;
				ST_FRC_EMIT: begin
					j_q <= j_next;
					if (j_next < n_eff)
						state_q <= ST_FRC_DIFF;
					else
						state_q <= ST_FRC_LAST;
				end
				ST_FRC_LAST:  state_q <= ST_FRD;
				ST_FRD:       state_q <= ST_FIN;
				ST_FIN: begin
					// wait for the output register to free up
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (r0_we)
			r0_q <= alu_y;
		if (r1_we)
			r1_q <= alu_y;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					idx_q     <= s_tdata[IDX_W-1:0];
					pos_in_q  <= s_tdata[41:10];
					noise_q   <= s_tdata[57:42];
					ext_q     <= s_tdata[58] ? s_tdata[90:59] : 32'd0;
					pos_res_q <= '0;
				end
			end
			ST_READ2:     pos_res_q <= pos_rd_q;
			ST_ADV_WRITE: pos_res_q <= r0_q[31:0];
			ST_FRC_PREV:  prev_q    <= pos_rd_q;
			ST_FRC_DIFF:  prev_q    <= pos_rd_q;
			ST_FRC_SPAN:  in_rng_q  <= !r0_q[DW-1] && (r0_q != '0) && (r0_q < ONE_Q20);
			ST_FRC_EMIT: begin
				fprev_q <= f_cur;
				if (j_q == '0)
					f0_q <= f_cur;
			end
			ST_FIN: begin
				if (slot_free)
					m_tdata_q <= {frc_rd_q, pos_res_q};
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/core/rsl_alu.sv
module rsl_alu import rsl_pkg::*; (
	input  alu_op_t               op,
	input  logic signed [DW-1:0]  a,
	input  logic signed [DW-1:0]  b,
	input  logic        [31:0]    box_length,
	output logic signed [DW-1:0]  y
);

	logic signed [PROD_W-1:0] prod;
	logic signed [DW:0]       two_a;
	logic signed [DW:0]       len_w;
	logic signed [DW-1:0]     len_d;

	assign prod  = $signed(a[MA_W-1:0]) * $signed(b[MB_W-1:0]);
	assign two_a = {a, 1'b0};
	assign len_w = $signed({{(DW + 1 - 32){1'b0}}, box_length});
	assign len_d = $signed({{(DW - 32){1'b0}}, box_length});

	always_comb begin
		case (op)
			ALU_ADD:   y = a + b;
			ALU_SUB:   y = a - b;
			ALU_MUL:   y = {{(DW - PROD_W){prod[PROD_W-1]}}, prod};
			ALU_ASR8:  y = a >>> 8;
			ALU_ASR16: y = a >>> 16;
			ALU_WRAP: begin
				// one add or subtract of the ring length into [-L/2, L/2)
				if (two_a >= len_w)
					y = a - len_d;
				else if (two_a < -len_w)
					y = a + len_d;
				else
					y = a;
			end
			ALU_SAT: begin
				if (a > S32_MAX)
					y = S32_MAX;
				else if (a < S32_MIN)
					y = S32_MIN;
				else
					y = a;
			end
			default:   y = a;
		endcase
	end

endmodule
